### rtl/slx_pkg.sv
// Shared types, token codes and character helpers for the source lexer.
// No dependencies; used by every rtl file through scoped names.
package slx_pkg;

  localparam int PosW  = 16;
  localparam int LineW = 16;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_IDENT,
    MODE_INT,
    MODE_DOT,
    MODE_FRAC,
    MODE_STR,
    MODE_OP,
    MODE_COMMENT
  } mode_e;

  localparam logic [5:0] KIND_END        = 6'd0;
  localparam logic [5:0] KIND_IDENT      = 6'd1;
  localparam logic [5:0] KIND_MUT        = 6'd2;
  localparam logic [5:0] KIND_NUM        = 6'd3;
  localparam logic [5:0] KIND_STR        = 6'd4;
  localparam logic [5:0] KIND_ERR_CHAR   = 6'd5;
  localparam logic [5:0] KIND_ERR_STR    = 6'd6;
  localparam logic [5:0] KIND_KW0        = 6'd7;
  localparam logic [5:0] KIND_SINGLE0    = 6'd28;
  localparam logic [5:0] KIND_DOT_EQ     = 6'd50;
  localparam logic [5:0] KIND_DOT_DOT    = 6'd51;
  localparam logic [5:0] KIND_COMMA_PAIR = 6'd52;
  localparam logic [5:0] KIND_BANG_TILDE = 6'd60;
  localparam logic [5:0] KIND_NONE       = 6'd0;

  localparam logic [1:0] CLS_VOID = 2'd0;
  localparam logic [1:0] CLS_NAME = 2'd1;
  localparam logic [1:0] CLS_NUM  = 2'd2;
  localparam logic [1:0] CLS_STR  = 2'd3;

  localparam logic [4:0] OP_NONE     = 5'd31;
  localparam logic [4:0] OP_FIRST_LA = 5'd12; // first operator that may pair
  localparam logic [4:0] OP_DOT      = 5'd12;

  localparam logic [PosW-1:0]  POS_MAX  = '1;
  localparam logic [LineW-1:0] LINE_MAX = '1;

  // name prefix holds up to seven bytes, first byte in the top bits
  localparam int NumKw = 21;
  localparam logic [55:0] KW_NAMES [NumKw] = '{
    {"and", 32'd0}, {"as", 40'd0}, {"define", 8'd0}, {"do", 40'd0},
    {"else", 24'd0}, {"false", 16'd0}, {"if", 40'd0}, {"is", 40'd0},
    {"let", 32'd0}, {"null", 24'd0}, {"or", 40'd0}, {"print", 16'd0},
    {"return", 8'd0}, {"to", 40'd0}, {"true", 24'd0}, {"use", 32'd0},
    {"unless", 8'd0}, {"until", 16'd0}, {"when", 24'd0}, {"while", 16'd0},
    {"quit", 24'd0}
  };

  typedef struct packed {
    logic [5:0]       kind;
    logic [PosW-1:0]  start;
    logic [PosW-1:0]  len;
    logic [LineW-1:0] line;
    logic [1:0]       cls;
  } tok_t;

  typedef struct packed {
    logic [2:0]       cnt;
    tok_t [3:0]       tk;
  } bundle_t;

  function automatic tok_t mk_tok(input logic [5:0] kind, input logic [PosW-1:0] start,
                                  input logic [PosW-1:0] len,
                                  input logic [LineW-1:0] line, input logic [1:0] cls);
    tok_t t;
    t.kind  = kind;
    t.start = start;
    t.len   = len;
    t.line  = line;
    t.cls   = cls;
    return t;
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic [4:0] op_index(input logic [7:0] c);
    logic [4:0] k;
    case (c)
      "(":     k = 5'd0;
      ")":     k = 5'd1;
      "{":     k = 5'd2;
      "}":     k = 5'd3;
      "?":     k = 5'd4;
      ";":     k = 5'd5;
      "=":     k = 5'd6;
      "-":     k = 5'd7;
      "&":     k = 5'd8;
      "|":     k = 5'd9;
      "^":     k = 5'd10;
      "~":     k = 5'd11;
      ".":     k = 5'd12;
      ",":     k = 5'd13;
      "%":     k = 5'd14;
      "+":     k = 5'd15;
      "/":     k = 5'd16;
      "*":     k = 5'd17;
      ":":     k = 5'd18;
      "<":     k = 5'd19;
      ">":     k = 5'd20;
      "!":     k = 5'd21;
      default: k = OP_NONE;
    endcase
    return k;
  endfunction

  // two-character operator code, KIND_NONE when the pair does not exist
  function automatic logic [5:0] pair_code(input logic [7:0] f, input logic [7:0] c);
    logic [4:0] j;
    logic [5:0] r;
    j = op_index(f);
    r = KIND_NONE;
    if (f == ".") begin
      if (c == "=") r = KIND_DOT_EQ;
      else if (c == ".") r = KIND_DOT_DOT;
    end else if (f == ",") begin
      if (c == ",") r = KIND_COMMA_PAIR;
    end else if (f == "!") begin
      if (c == "~") r = KIND_BANG_TILDE;
    end else if (j != OP_NONE && j > OP_FIRST_LA + 5'd1 && c == "=") begin
      r = KIND_DOT_DOT + {1'b0, j - OP_FIRST_LA};
    end
    return r;
  endfunction

  function automatic logic [5:0] name_kind(input logic [55:0] px);
    logic [5:0] k;
    k = KIND_IDENT;
    if (px[55:48] == "#") begin
      k = KIND_MUT;
    end else begin
      for (int i = 0; i < NumKw; i++) begin
        if (px == KW_NAMES[i]) k = KIND_KW0 + 6'(i);
      end
    end
    return k;
  endfunction

  function automatic logic [5:0] single_kind(input logic [4:0] k);
    return KIND_SINGLE0 + {1'b0, k};
  endfunction

endpackage

### rtl/slx_scan.sv
// Front end: scan state machine, turns one accepted item into a bundle of tokens.
// Depends on slx_pkg.
module slx_scan (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic [7:0]       char_byte_i,
  input  logic             byte_valid_i,
  input  logic             end_of_source_i,
  output logic             push_o,
  output slx_pkg::bundle_t bundle_o
);

  slx_pkg::mode_e            mode_q, mode_d;
  logic [slx_pkg::PosW-1:0]  tstart_q, tstart_d;
  logic [slx_pkg::PosW-1:0]  tlen_q, tlen_d;
  logic [slx_pkg::PosW-1:0]  rpos_q, rpos_d;
  logic [slx_pkg::LineW-1:0] line_q, line_d;
  logic [55:0]               prefix_q, prefix_d;
  logic                      hash_q, hash_d;
  slx_pkg::bundle_t          bnd;

  always_comb begin
    logic [7:0] c;
    logic [2:0] n;
    logic       run_idle;
    logic [4:0] k;
    logic [5:0] pc;
    logic [7:0] f;
    logic [slx_pkg::PosW-1:0] prev;

    c        = char_byte_i;
    n        = 3'd0;
    run_idle = 1'b0;
    bnd      = '0;
    mode_d   = mode_q;
    tstart_d = tstart_q;
    tlen_d   = tlen_q;
    rpos_d   = rpos_q;
    line_d   = line_q;
    prefix_d = prefix_q;
    hash_d   = hash_q;
    k        = slx_pkg::op_index(c);
    f        = prefix_q[55:48];
    pc       = slx_pkg::pair_code(f, c);
    prev     = rpos_q - 1'b1;

    if (byte_valid_i) begin
      case (mode_q)
        slx_pkg::MODE_IDLE: begin
          run_idle = 1'b1;
        end
        slx_pkg::MODE_IDENT: begin
          if (slx_pkg::is_alpha(c) || slx_pkg::is_digit(c) ||
              (c == "#" && tlen_q == 1 && !hash_q)) begin
            if (c == "#") hash_d = 1'b1;
            for (int i = 1; i < 7; i++) begin
              if (tlen_q == slx_pkg::PosW'(i)) prefix_d[(6-i)*8 +: 8] = c;
            end
            if (tlen_q != slx_pkg::POS_MAX) tlen_d = tlen_q + 1'b1;
          end else begin
            bnd.tk[n[1:0]] = slx_pkg::mk_tok(slx_pkg::name_kind(prefix_q), tstart_q, tlen_q,
                                             line_d, slx_pkg::CLS_NAME);
            n = n + 3'd1;
            mode_d = slx_pkg::MODE_IDLE;
            run_idle = 1'b1;
          end
        end
        slx_pkg::MODE_INT, slx_pkg::MODE_FRAC: begin
          if (slx_pkg::is_digit(c)) begin
            if (tlen_q != slx_pkg::POS_MAX) tlen_d = tlen_q + 1'b1;
          end else if (c == "." && mode_q == slx_pkg::MODE_INT) begin
            if (tlen_q != slx_pkg::POS_MAX) tlen_d = tlen_q + 1'b1;
            mode_d = slx_pkg::MODE_DOT;
          end else begin
            bnd.tk[n[1:0]] = slx_pkg::mk_tok(slx_pkg::KIND_NUM, tstart_q, tlen_q, line_d,
                                             slx_pkg::CLS_NUM);
            n = n + 3'd1;
            mode_d = slx_pkg::MODE_IDLE;
            run_idle = 1'b1;
          end
        end
        slx_pkg::MODE_DOT: begin
          if (slx_pkg::is_digit(c)) begin
            if (tlen_q != slx_pkg::POS_MAX) tlen_d = tlen_q + 1'b1;
            mode_d = slx_pkg::MODE_FRAC;
          end else begin
            // number without the dot, then the dot as an operator
            bnd.tk[n[1:0]] = slx_pkg::mk_tok(slx_pkg::KIND_NUM, tstart_q,
                (tlen_q == slx_pkg::POS_MAX) ? tlen_q : tlen_q - 1'b1,
                line_d, slx_pkg::CLS_NUM);
            n = n + 3'd1;
            mode_d = slx_pkg::MODE_IDLE;
            if (c == "=" || c == ".") begin
              bnd.tk[n[1:0]] = slx_pkg::mk_tok(
                  slx_pkg::pair_code(8'("."), c), prev, slx_pkg::PosW'(2), line_d,
                  slx_pkg::CLS_VOID);
              n = n + 3'd1;
            end else begin
              bnd.tk[n[1:0]] = slx_pkg::mk_tok(slx_pkg::single_kind(slx_pkg::OP_DOT), prev,
                  slx_pkg::PosW'(1), line_d, slx_pkg::CLS_VOID);
              n = n + 3'd1;
              run_idle = 1'b1;
            end
          end
        end
        slx_pkg::MODE_STR: begin
          if (tlen_q != slx_pkg::POS_MAX) tlen_d = tlen_q + 1'b1;
          if (c == "\"") begin
            bnd.tk[n[1:0]] = slx_pkg::mk_tok(slx_pkg::KIND_STR, tstart_q, tlen_d, line_d,
                                             slx_pkg::CLS_STR);
            n = n + 3'd1;
            mode_d = slx_pkg::MODE_IDLE;
          end else if (c == "\n") begin
            if (line_q != slx_pkg::LINE_MAX) line_d = line_q + 1'b1;
          end
        end
        slx_pkg::MODE_OP: begin
          if (f == "/" && c == "/") begin
            mode_d = slx_pkg::MODE_COMMENT;
          end else if (pc != slx_pkg::KIND_NONE) begin
            if (tlen_q != slx_pkg::POS_MAX) tlen_d = tlen_q + 1'b1;
            bnd.tk[n[1:0]] = slx_pkg::mk_tok(pc, tstart_q, tlen_d, line_d, slx_pkg::CLS_VOID);
            n = n + 3'd1;
            mode_d = slx_pkg::MODE_IDLE;
          end else begin
            bnd.tk[n[1:0]] = slx_pkg::mk_tok(slx_pkg::single_kind(slx_pkg::op_index(f)),
                tstart_q, slx_pkg::PosW'(1), line_d, slx_pkg::CLS_VOID);
            n = n + 3'd1;
            mode_d = slx_pkg::MODE_IDLE;
            run_idle = 1'b1;
          end
        end
        slx_pkg::MODE_COMMENT: begin
          if (c == "\n") begin
            mode_d = slx_pkg::MODE_IDLE;
            run_idle = 1'b1;
          end
        end
        default: begin
          mode_d = slx_pkg::MODE_IDLE;
          run_idle = 1'b1;
        end
      endcase

      if (run_idle) begin
        if (c == " " || c == "\r" || c == "\t") begin
          // whitespace is dropped
        end else if (c == "\n") begin
          if (line_d != slx_pkg::LINE_MAX) line_d = line_d + 1'b1;
        end else if (slx_pkg::is_alpha(c) || c == "#" || slx_pkg::is_digit(c) ||
                     c == "\"" || (k != slx_pkg::OP_NONE && k >= slx_pkg::OP_FIRST_LA)) begin
          tstart_d = rpos_q;
          tlen_d   = slx_pkg::PosW'(1);
          prefix_d = '0;
          hash_d   = 1'b0;
          if (slx_pkg::is_digit(c)) begin
            mode_d = slx_pkg::MODE_INT;
          end else if (c == "\"") begin
            mode_d = slx_pkg::MODE_STR;
          end else if (slx_pkg::is_alpha(c) || c == "#") begin
            mode_d = slx_pkg::MODE_IDENT;
            prefix_d = {c, 48'd0};
          end else begin
            mode_d = slx_pkg::MODE_OP;
            prefix_d = {c, 48'd0};
          end
        end else begin
          tstart_d = rpos_q;
          bnd.tk[n[1:0]] = slx_pkg::mk_tok(
              (k != slx_pkg::OP_NONE) ? slx_pkg::single_kind(k) : slx_pkg::KIND_ERR_CHAR,
              rpos_q, slx_pkg::PosW'(1), line_d, slx_pkg::CLS_VOID);
          n = n + 3'd1;
        end
      end
      rpos_d = rpos_q + 1'b1;
    end

    if (end_of_source_i) begin
      case (mode_d)
        slx_pkg::MODE_IDENT: begin
          bnd.tk[n[1:0]] = slx_pkg::mk_tok(slx_pkg::name_kind(prefix_d), tstart_d, tlen_d,
                                           line_d, slx_pkg::CLS_NAME);
          n = n + 3'd1;
        end
        slx_pkg::MODE_INT, slx_pkg::MODE_FRAC: begin
          bnd.tk[n[1:0]] = slx_pkg::mk_tok(slx_pkg::KIND_NUM, tstart_d, tlen_d, line_d,
                                           slx_pkg::CLS_NUM);
          n = n + 3'd1;
        end
        slx_pkg::MODE_DOT: begin
          bnd.tk[n[1:0]] = slx_pkg::mk_tok(slx_pkg::KIND_NUM, tstart_d,
              (tlen_d == slx_pkg::POS_MAX) ? tlen_d : tlen_d - 1'b1, line_d, slx_pkg::CLS_NUM);
          n = n + 3'd1;
          bnd.tk[n[1:0]] = slx_pkg::mk_tok(slx_pkg::single_kind(slx_pkg::OP_DOT),
              rpos_d - 1'b1, slx_pkg::PosW'(1), line_d, slx_pkg::CLS_VOID);
          n = n + 3'd1;
        end
        slx_pkg::MODE_OP: begin
          bnd.tk[n[1:0]] = slx_pkg::mk_tok(slx_pkg::single_kind(slx_pkg::op_index(
              prefix_d[55:48])), tstart_d, slx_pkg::PosW'(1), line_d, slx_pkg::CLS_VOID);
          n = n + 3'd1;
        end
        slx_pkg::MODE_STR: begin
          bnd.tk[n[1:0]] = slx_pkg::mk_tok(slx_pkg::KIND_ERR_STR, tstart_d, tlen_d, line_d,
                                           slx_pkg::CLS_VOID);
          n = n + 3'd1;
        end
        default: begin
        end
      endcase
      bnd.tk[n[1:0]] = slx_pkg::mk_tok(slx_pkg::KIND_END, rpos_d, '0, line_d,
                                       slx_pkg::CLS_VOID);
      n = n + 3'd1;
      mode_d   = slx_pkg::MODE_IDLE;
      tstart_d = '0;
      tlen_d   = '0;
      rpos_d   = '0;
      line_d   = slx_pkg::LineW'(1);
      prefix_d = '0;
      hash_d   = 1'b0;
    end
    bnd.cnt = n;
  end

  assign push_o   = accept_i && (bnd.cnt != 3'd0);
  assign bundle_o = bnd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= slx_pkg::MODE_IDLE;
      tstart_q <= '0;
      tlen_q   <= '0;
      rpos_q   <= '0;
      line_q   <= slx_pkg::LineW'(1);
      prefix_q <= '0;
      hash_q   <= 1'b0;
    end else if (accept_i) begin
      mode_q   <= mode_d;
      tstart_q <= tstart_d;
      tlen_q   <= tlen_d;
      rpos_q   <= rpos_d;
      line_q   <= line_d;
      prefix_q <= prefix_d;
      hash_q   <= hash_d;
    end
  end

endmodule

### rtl/slx_queue.sv
// Two-entry queue of token bundles between scanner and token emitter.
// Depends on slx_pkg.
module slx_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  slx_pkg::bundle_t push_data_i,
  input  logic             pop_i,
  output logic             full_o,
  output logic             nonempty_o,
  output slx_pkg::bundle_t head_o
);

  slx_pkg::bundle_t mem_q [2];
  logic             wptr_q, rptr_q;
  logic [1:0]       count_q;

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wptr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      count_q <= 2'd0;
    end else begin
      if (push_i) wptr_q <= ~wptr_q;
      if (pop_i) rptr_q <= ~rptr_q;
      count_q <= count_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  assign full_o     = count_q == 2'd2;
  assign nonempty_o = count_q != 2'd0;
  assign head_o     = mem_q[rptr_q];

endmodule

### rtl/slx_emit.sv
// Back end: walks the head bundle and presents its tokens one transfer at a time.
// Depends on slx_pkg.
module slx_emit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      head_valid_i,
  input  slx_pkg::bundle_t          head_i,
  output logic                      pop_o,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [5:0]                token_kind_o,
  output logic [slx_pkg::PosW-1:0]  start_offset_o,
  output logic [slx_pkg::PosW-1:0]  token_len_o,
  output logic [slx_pkg::LineW-1:0] line_number_o,
  output logic [1:0]                value_class_o,
  output logic                      last_token_o
);

  logic [1:0]    idx_q;
  slx_pkg::tok_t tok;
  logic          last;

  assign tok  = head_i.tk[idx_q];
  assign last = {1'b0, idx_q} == head_i.cnt - 3'd1;

  assign out_valid_o    = head_valid_i;
  assign token_kind_o   = tok.kind;
  assign start_offset_o = tok.start;
  assign token_len_o    = tok.len;
  assign line_number_o  = tok.line;
  assign value_class_o  = tok.cls;
  assign last_token_o   = last;
  assign pop_o          = head_valid_i && !out_stall_i && last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= 2'd0;
    end else if (head_valid_i && !out_stall_i) begin
      idx_q <= last ? 2'd0 : idx_q + 2'd1;
    end
  end

endmodule

### rtl/source_lexer_core.sv
// Top level of the source lexer: scanner front end, bundle queue, token emitter.
// Depends on slx_pkg, slx_scan, slx_queue, slx_emit.
//
// Usage:
//  - Input channel (in_valid_i / in_stall_o) carries one source byte per transfer
//    (byte_valid_i qualifies char_byte_i) plus end_of_source_i, which flushes any
//    pending token, appends an end token and returns the scanner to its reset state.
//  - Output channel (out_valid_o / out_stall_i) carries one token per transfer;
//    last_token_o marks the final token caused by one input transfer.
//  - The scanner updates its state in the cycle a byte is taken, so one input
//    transfer is taken every cycle while the queue has room.
//  - A byte yields zero to four tokens. They are packed into one bundle and written
//    to a two-entry queue; the emitter presents one token per output transfer, so an
//    item with n tokens occupies the output for n transfers.
//  - The bundle is registered in the queue; the emitter presents tokens from its head.
//  - When the receiver stalls, the queue fills and in_stall_o rises after two
//    bundles are waiting; items producing no token never enter the queue.
//  - Reset (rst_ni low, asynchronous) empties the queue and sets line count to one,
//    position and length to zero.
module source_lexer_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [7:0]                char_byte_i,
  input  logic                      byte_valid_i,
  input  logic                      end_of_source_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [5:0]                token_kind_o,
  output logic [slx_pkg::PosW-1:0]  start_offset_o,
  output logic [slx_pkg::PosW-1:0]  token_len_o,
  output logic [slx_pkg::LineW-1:0] line_number_o,
  output logic [1:0]                value_class_o,
  output logic                      last_token_o
);

  logic             accept;
  logic             push;
  logic             pop;
  logic             full;
  logic             nonempty;
  slx_pkg::bundle_t bundle;
  slx_pkg::bundle_t head;

  // input transfer happens whenever the queue can take a bundle
  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  slx_scan u_scan (
    .clk_i,
    .rst_ni,
    .accept_i        (accept),
    .char_byte_i,
    .byte_valid_i,
    .end_of_source_i,
    .push_o          (push),
    .bundle_o        (bundle)
  );

  slx_queue u_queue (
    .clk_i,
    .rst_ni,
    .push_i      (push),
    .push_data_i (bundle),
    .pop_i       (pop),
    .full_o      (full),
    .nonempty_o  (nonempty),
    .head_o      (head)
  );

  slx_emit u_emit (
    .clk_i,
    .rst_ni,
    .head_valid_i (nonempty),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o,
    .out_stall_i,
    .token_kind_o,
    .start_offset_o,
    .token_len_o,
    .line_number_o,
    .value_class_o,
    .last_token_o
  );

endmodule
